### sv/kcp_pkg.sv
`default_nettype none
package kcp_pkg;

	localparam int MAX_SAMPLES   = 256;
	localparam int CNT_W         = $clog2(MAX_SAMPLES);
	localparam int N_W           = $clog2(MAX_SAMPLES + 1);
	localparam int KERNEL_DEPTH  = 511;
	localparam int KERNEL_OFFSET = 255;
	localparam int KIDX_W        = 9;
	localparam int KVAL_W        = 16;
	localparam int NUM_ROWS      = 3;
	localparam int SUM_W         = KVAL_W + N_W;
	localparam int DSTEP_W       = $clog2(SUM_W + 1);

	typedef enum logic [1:0] {
		FUNC_ADD   = 2'd0,
		FUNC_QUERY = 2'd1,
		FUNC_LOAD  = 2'd2,
		FUNC_CLEAR = 2'd3
	} func_t;

	typedef struct packed {
		logic [7:0] a;
		logic [7:0] b;
		logic [7:0] c;
	} pixel_t;

	typedef struct packed {
		logic [1:0]        func;
		logic [7:0]        chan_a;
		logic [7:0]        chan_b;
		logic [7:0]        chan_c;
		logic [1:0]        kernel_row;
		logic [KIDX_W-1:0] kernel_index;
		logic [KVAL_W-1:0] kernel_value;
	} in_item_t;

	typedef struct packed {
		logic [15:0]    probability;
		logic [N_W-1:0] samples_used;
	} out_item_t;

	typedef struct packed {
		logic             start;
		logic [SUM_W-1:0] dividend;
		logic [N_W-1:0]   divisor;
	} div_req_t;

	function automatic logic [KIDX_W-1:0] kidx(input logic [7:0] q, input logic [7:0] s);
		return KIDX_W'({1'b0, q}) + KIDX_W'(KERNEL_OFFSET) - KIDX_W'({1'b0, s});
	endfunction

endpackage
`default_nettype wire

### sv/kcp_cell.sv
`default_nettype none
module kcp_cell (
	input  wire logic            clk,
	input  wire logic            en,
	input  wire kcp_pkg::pixel_t d,
	output kcp_pkg::pixel_t      q
);
	import kcp_pkg::*;

	pixel_t px_q;

	always_ff @(posedge clk) begin
		if (en) begin
			px_q <= d;
		end
	end

	assign q = px_q;
endmodule
`default_nettype wire

### sv/kcp_kernel_ram.sv
`default_nettype none
module kcp_kernel_ram (
	input  wire logic                       clk,
	input  wire logic                       we,
	input  wire logic [kcp_pkg::KIDX_W-1:0] waddr,
	input  wire logic [kcp_pkg::KVAL_W-1:0] wdata,
	input  wire logic [kcp_pkg::KIDX_W-1:0] raddr,
	output logic [kcp_pkg::KVAL_W-1:0]      rdata
);
	import kcp_pkg::*;

	logic [KVAL_W-1:0] mem [KERNEL_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

### sv/kcp_divider.sv
`default_nettype none
module kcp_divider (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire kcp_pkg::div_req_t req,
	output logic                   done,
	output logic [15:0]            quotient
);
	import kcp_pkg::*;

	logic [SUM_W-1:0]   quo_q;
	logic [N_W-1:0]     rem_q;
	logic [N_W-1:0]     div_q;
	logic [DSTEP_W-1:0] step_q;
	logic               run_q;
	logic               done_q;
	logic [N_W:0]       trial;
	logic               ge;

	assign trial = {rem_q, quo_q[SUM_W-1]};
	assign ge    = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == DSTEP_W'(SUM_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// one restoring step per cycle, quotient bits shift in from the right
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			div_q <= req.divisor;
		end else if (run_q) begin
			quo_q <= {quo_q[SUM_W-2:0], ge};
			rem_q <= ge ? N_W'(trial - {1'b0, div_q}) : N_W'(trial);
		end
	end

	assign done     = done_q;
	assign quotient = quo_q[15:0];
endmodule
`default_nettype wire

### sv/kde_color_probability.sv
`default_nettype none
// Kernel density color model. Samples sit in a ring of 256 cells; an add item
// shifts a new pixel in at the head and, once the ring is full, pushes the oldest
// out at the tail. A load item writes one entry of a channel's 511-entry kernel
// table. A query rotates the ring once around, one sample per cycle through the
// kernel tables and a two-stage multiplier, then divides the sum by the sample
// count with a one-bit-per-cycle divider. Add, load and clear items leave the
// block idle and ready for the next item; a query holds off new items until its
// result is registered. A query with no samples returns 0.
module kde_color_probability (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire kcp_pkg::in_item_t   in_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output kcp_pkg::out_item_t       out_data
);
	import kcp_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_RUN   = 5'b00010,
		ST_DRAIN = 5'b00100,
		ST_DIV   = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  t_q;
	logic [1:0]        drain_q;
	logic [N_W-1:0]    count_q;
	logic [N_W-1:0]    n_q;
	pixel_t            qpix_q;
	logic [SUM_W-1:0]  sum_q;
	logic [15:0]       prob_q;
	logic              out_valid_q;
	out_item_t         out_q;

	logic              accept;
	logic              add_en;
	logic              rotate;
	logic              shift_en;
	pixel_t            head_in;
	pixel_t            cell_q [MAX_SAMPLES];
	pixel_t            tap;

	logic                    v_s1, v_s2, v_s3;
	logic [KVAL_W-1:0]       k0_s1, k1_s1, k2_s1;
	logic [KVAL_W-1:0]       k2_s2;
	logic [2*KVAL_W-1:0]     p_s2;
	logic [KVAL_W-1:0]       term_s3;
	logic [3*KVAL_W-1:0]     p3;
	logic                    issue_v;
	logic                    load_ok;
	logic [NUM_ROWS-1:0]     we;
	logic [KIDX_W-1:0]       ra0, ra1, ra2;
	div_req_t                dreq;
	logic                    ddone;
	logic [15:0]             dquo;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign add_en   = accept && (in_data.func == FUNC_ADD);
	assign rotate   = (state_q == ST_RUN);
	assign shift_en = add_en || rotate;
	assign tap      = cell_q[MAX_SAMPLES-1];
	assign head_in  = rotate ? tap : pixel_t'{in_data.chan_a, in_data.chan_b, in_data.chan_c};

	for (genvar i = 0; i < MAX_SAMPLES; i++) begin : g_ring
		kcp_cell u_cell (
			.clk (clk),
			.en  (shift_en),
			.d   ((i == 0) ? head_in : cell_q[(i == 0) ? 0 : i - 1]),
			.q   (cell_q[i])
		);
	end

	assign load_ok = accept && (in_data.func == FUNC_LOAD)
		&& (in_data.kernel_index < KIDX_W'(KERNEL_DEPTH));
	always_comb begin
		for (int r = 0; r < NUM_ROWS; r++) begin
			we[r] = load_ok && (in_data.kernel_row == 2'(r));
		end
	end

	assign ra0 = kidx(qpix_q.a, tap.a);
	assign ra1 = kidx(qpix_q.b, tap.b);
	assign ra2 = kidx(qpix_q.c, tap.c);

	kcp_kernel_ram u_k0 (.clk(clk), .we(we[0]), .waddr(in_data.kernel_index),
		.wdata(in_data.kernel_value), .raddr(ra0), .rdata(k0_s1));
	kcp_kernel_ram u_k1 (.clk(clk), .we(we[1]), .waddr(in_data.kernel_index),
		.wdata(in_data.kernel_value), .raddr(ra1), .rdata(k1_s1));
	kcp_kernel_ram u_k2 (.clk(clk), .we(we[2]), .waddr(in_data.kernel_index),
		.wdata(in_data.kernel_value), .raddr(ra2), .rdata(k2_s1));

	// tail holds the oldest cell first; only the last n steps carry stored samples
	assign issue_v = rotate && ({1'b0, t_q} >= (N_W'(MAX_SAMPLES) - n_q));
	assign p3      = p_s2 * k2_s2;

	always_ff @(posedge clk) begin
		p_s2    <= k0_s1 * k1_s1;
		k2_s2   <= k2_s1;
		term_s3 <= p3[3*KVAL_W-1:2*KVAL_W];
	end

	assign dreq.start    = (state_q == ST_DRAIN) && (drain_q == 2'd3) && (n_q != '0);
	assign dreq.dividend = sum_q;
	assign dreq.divisor  = n_q;

	kcp_divider u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .done(ddone), .quotient(dquo));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			t_q         <= '0;
			drain_q     <= '0;
			count_q     <= '0;
			n_q         <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= issue_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (in_data.func)
							FUNC_ADD: begin
								if (count_q != N_W'(MAX_SAMPLES)) begin
									count_q <= count_q + 1'b1;
								end
							end
							FUNC_QUERY: begin
								n_q     <= count_q;
								t_q     <= '0;
								state_q <= ST_RUN;
							end
							FUNC_CLEAR: count_q <= '0;
							default: ;
						endcase
					end
				end
				ST_RUN: begin
					t_q <= t_q + 1'b1;
					if (t_q == CNT_W'(MAX_SAMPLES - 1)) begin
						drain_q <= '0;
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					drain_q <= drain_q + 1'b1;
					if (drain_q == 2'd3) begin
						state_q <= (n_q == '0) ? ST_DONE : ST_DIV;
					end
				end
				ST_DIV: begin
					if (ddone) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (in_data.func == FUNC_QUERY)) begin
			qpix_q <= pixel_t'{in_data.chan_a, in_data.chan_b, in_data.chan_c};
			sum_q  <= '0;
		end else if (v_s3) begin
			sum_q <= sum_q + SUM_W'(term_s3);
		end
		if (ddone) begin
			prob_q <= dquo;
		end
		if ((state_q == ST_DONE) && (!out_valid_q || out_ready)) begin
			out_q.probability  <= (n_q == '0) ? 16'd0 : prob_q;
			out_q.samples_used <= n_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;
endmodule
`default_nettype wire

### tb/sv/tb_top.sv
`default_nettype none
module tb_top;
	import kcp_pkg::*;

	// Predicts query densities and holds them until the block returns them.
	class density_board;
		logic [7:0]  store_a [MAX_SAMPLES];
		logic [7:0]  store_b [MAX_SAMPLES];
		logic [7:0]  store_c [MAX_SAMPLES];
		logic [15:0] kernel [NUM_ROWS][KERNEL_DEPTH];
		int unsigned head;
		int unsigned count;
		out_item_t   pending[$];
		int          errors;

		function new();
			head = 0;
			count = 0;
			errors = 0;
			foreach (kernel[r, i]) kernel[r][i] = '0;
		endfunction

		function logic [63:0] weight(int row, logic [7:0] q, logic [7:0] s);
			int idx;
			idx = int'(q) + KERNEL_OFFSET - int'(s);
			return {48'd0, kernel[row][idx]};
		endfunction

		function void note_item(in_item_t it);
			logic [63:0] sum;
			logic [63:0] prob;
			out_item_t   r;
			case (func_t'(it.func))
				FUNC_ADD: begin
					store_a[head] = it.chan_a;
					store_b[head] = it.chan_b;
					store_c[head] = it.chan_c;
					head = (head + 1) % MAX_SAMPLES;
					if (count < MAX_SAMPLES)
						count++;
				end
				FUNC_QUERY: begin
					sum = 0;
					for (int i = 0; i < count; i++)
						sum += (weight(0, it.chan_a, store_a[i]) *
							weight(1, it.chan_b, store_b[i]) *
							weight(2, it.chan_c, store_c[i])) >> 32;
					prob = (count > 0) ? sum / count : 0;
					if (prob > 64'hFFFF)
						prob = 64'hFFFF;
					r.probability = prob[15:0];
					r.samples_used = N_W'(count);
					pending.push_back(r);
				end
				FUNC_LOAD: begin
					if (it.kernel_row < NUM_ROWS && it.kernel_index < KERNEL_DEPTH)
						kernel[it.kernel_row][it.kernel_index] = it.kernel_value;
				end
				default: begin
					count = 0;
					head = 0;
				end
			endcase
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result prob=%h used=%0d", $time,
					got.probability, got.samples_used);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.probability !== want.probability) begin
				$display("%0t: probability expected %h actual %h", $time,
					want.probability, got.probability);
				errors++;
			end
			if (got.samples_used !== want.samples_used) begin
				$display("%0t: samples_used expected %0d actual %0d", $time,
					want.samples_used, got.samples_used);
				errors++;
			end
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_data;

	density_board board;
	int send_idle;
	int recv_stall;
	int hold_off;

	kde_color_probability dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#12000000;
		$display("tb_top: errors");
		$finish;
	end

	// Receiver: random stalls, plus a long hold-off when requested.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				board.check_result(out_data);
			if (hold_off > 0) begin
				hold_off <= hold_off - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall);
			end
		end
	end

	// Leave valid high after the accepting edge; the next send replaces the item, or a drain drops valid.
	task automatic send(in_item_t it);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		board.note_item(it);
	endtask

	function automatic in_item_t make_item(func_t f, int a, int b, int c);
		in_item_t it;
		it = '0;
		it.func = f;
		it.chan_a = 8'(a);
		it.chan_b = 8'(b);
		it.chan_c = 8'(c);
		it.kernel_row = 2'($urandom_range(3));
		it.kernel_index = 9'($urandom);
		it.kernel_value = 16'($urandom);
		return it;
	endfunction

	task automatic load_kernel(int row, int idx, int val);
		in_item_t it;
		it = make_item(FUNC_LOAD, $urandom, $urandom, $urandom);
		it.kernel_row = 2'(row);
		it.kernel_index = 9'(idx);
		it.kernel_value = 16'(val);
		send(it);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// Random traffic: mostly adds and queries, some loads, clears and noise.
	task automatic random_burst(int n);
		int pick;
		in_item_t it;
		for (int k = 0; k < n; k++) begin
			pick = $urandom_range(99);
			if (pick < 45)
				it = make_item(FUNC_ADD, $urandom, $urandom, $urandom);
			else if (pick < 75)
				it = make_item(FUNC_QUERY, $urandom, $urandom, $urandom);
			else if (pick < 97)
				it = make_item(FUNC_LOAD, $urandom, $urandom, $urandom);
			else
				it = make_item(FUNC_CLEAR, $urandom, $urandom, $urandom);
			send(it);
		end
	endtask

	initial begin
		board = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		send_idle = 0;
		recv_stall = 0;
		hold_off = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b0;
		#1 arst_n = 1'b1;
		@(posedge clk);

		// Fill every kernel entry so no query reads an unloaded one.
		for (int r = 0; r < NUM_ROWS; r++)
			for (int i = 0; i < KERNEL_DEPTH; i++)
				load_kernel(r, i, $urandom);

		// Directed: empty query, extremes, out-of-range loads, clear.
		send(make_item(FUNC_QUERY, 0, 0, 0));
		load_kernel(0, 0, 16'hFFFF);
		load_kernel(1, 510, 16'hFFFF);
		load_kernel(2, 255, 16'hFFFF);
		load_kernel(0, 255, 16'hFFFF);
		load_kernel(1, 255, 16'hFFFF);
		load_kernel(3, 100, 16'h1234);
		load_kernel(2, 511, 16'h5555);
		load_kernel(1, 9'h1FF, 0);
		send(make_item(FUNC_ADD, 255, 0, 128));
		send(make_item(FUNC_QUERY, 0, 255, 128));
		send(make_item(FUNC_QUERY, 255, 0, 128));
		send(make_item(FUNC_ADD, 0, 255, 0));
		send(make_item(FUNC_QUERY, 255, 255, 255));
		send(make_item(FUNC_QUERY, 0, 0, 0));
		send(make_item(FUNC_CLEAR, 0, 0, 0));
		send(make_item(FUNC_QUERY, 1, 2, 3));
		// Saturate the ring and wrap it.
		for (int k = 0; k < 300; k++)
			send(make_item(FUNC_ADD, $urandom, $urandom, $urandom));
		send(make_item(FUNC_QUERY, 255, 255, 255));
		send(make_item(FUNC_QUERY, 0, 0, 0));
		drain();

		// Long receiver hold-off while queries keep coming.
		hold_off = 3000;
		for (int k = 0; k < 8; k++)
			send(make_item(FUNC_QUERY, $urandom, $urandom, $urandom));
		drain();

		send(make_item(FUNC_CLEAR, 0, 0, 0));
		random_burst(125);
		send_idle = 62;
		random_burst(125);
		send_idle = 0;
		recv_stall = 62;
		random_burst(125);
		send_idle = 31;
		recv_stall = 31;
		random_burst(125);
		send_idle = 0;
		recv_stall = 0;
		drain();

		if (board.errors == 0 && board.pending.size() == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end
endmodule
`default_nettype wire

### filelist.f
sv/kcp_pkg.sv
sv/kcp_cell.sv
sv/kcp_kernel_ram.sv
sv/kcp_divider.sv
sv/kde_color_probability.sv
tb/sv/tb_top.sv
